/* rtl/ppp_pkg.sv */
// ppp_pkg: shared types and constants for the pinhole point projection pipeline.
// No dependencies; imported by every module under rtl/.
package ppp_pkg;

	localparam int CAM_W    = 40;
	localparam int AXIS_LAT = 4;

	localparam logic [15:0] QUAT_ONE  = 16'h4000;
	localparam logic [15:0] SCALE_ONE = 16'd256;

	typedef enum logic [2:0] {
		REG_ROT   = 3'd0,
		REG_TXY   = 3'd1,
		REG_TZ    = 3'd2,
		REG_FOCAL = 3'd3,
		REG_PRINC = 3'd4,
		REG_SCALE = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic last;
		logic zero;
		logic neg_x;
		logic neg_y;
	} div_tag_t;

	typedef struct packed {
		logic last;
		logic zero;
	} post_tag_t;

endpackage

/* rtl/ppp_rot.sv */
// ppp_rot: four-stage quaternion rotation and translation of one world point.
// Depends on ppp_pkg.
module ppp_rot import ppp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic signed [31:0]      wx,
	input  logic signed [31:0]      wy,
	input  logic signed [31:0]      wz,
	input  logic                    in_last,
	input  logic [63:0]             quat,
	input  logic [63:0]             txy,
	input  logic [31:0]             tz,
	output logic                    out_valid,
	output logic                    out_last,
	output logic signed [CAM_W-1:0] cam_x,
	output logic signed [CAM_W-1:0] cam_y,
	output logic signed [CAM_W-1:0] cam_z
);

	logic signed [15:0] qw, qx, qy, qz;
	logic signed [47:0] m_s1 [6];
	logic signed [31:0] v_s1 [3];
	logic signed [31:0] v_s2 [3];
	logic signed [31:0] v_s3 [3];
	logic signed [48:0] d [3];
	logic signed [35:0] t_s2 [3];
	logic signed [51:0] r_s3 [9];
	logic signed [53:0] u [3];
	logic signed [CAM_W+1:0] sum [3];
	logic signed [CAM_W-1:0] cam_s4 [3];
	logic signed [31:0] tr [3];
	logic last_s1, last_s2, last_s3, last_s4;
	logic vld_s1, vld_s2, vld_s3, vld_s4;

	assign qw = $signed(quat[63:48]);
	assign qx = $signed(quat[47:32]);
	assign qy = $signed(quat[31:16]);
	assign qz = $signed(quat[15:0]);
	assign tr[0] = $signed(txy[63:32]);
	assign tr[1] = $signed(txy[31:0]);
	assign tr[2] = $signed(tz);

	assign d[0] = 49'(m_s1[0]) - 49'(m_s1[1]);
	assign d[1] = 49'(m_s1[2]) - 49'(m_s1[3]);
	assign d[2] = 49'(m_s1[4]) - 49'(m_s1[5]);

	assign u[0] = 54'(r_s3[0]) + 54'(r_s3[1]) - 54'(r_s3[2]);
	assign u[1] = 54'(r_s3[3]) + 54'(r_s3[4]) - 54'(r_s3[5]);
	assign u[2] = 54'(r_s3[6]) + 54'(r_s3[7]) - 54'(r_s3[8]);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum[i] = (CAM_W+2)'(v_s3[i]) + (CAM_W+2)'($signed(u[i][53:14]))
				+ (CAM_W+2)'(tr[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1[0] <= qy * wz;
			m_s1[1] <= qz * wy;
			m_s1[2] <= qz * wx;
			m_s1[3] <= qx * wz;
			m_s1[4] <= qx * wy;
			m_s1[5] <= qy * wx;
			v_s1[0] <= wx;
			v_s1[1] <= wy;
			v_s1[2] <= wz;
			last_s1 <= in_last;
			for (int i = 0; i < 3; i++) begin
				t_s2[i] <= d[i][48:13];
			end
			v_s2    <= v_s1;
			last_s2 <= last_s1;
			r_s3[0] <= qw * t_s2[0];
			r_s3[1] <= qy * t_s2[2];
			r_s3[2] <= qz * t_s2[1];
			r_s3[3] <= qw * t_s2[1];
			r_s3[4] <= qz * t_s2[0];
			r_s3[5] <= qx * t_s2[2];
			r_s3[6] <= qw * t_s2[2];
			r_s3[7] <= qx * t_s2[1];
			r_s3[8] <= qy * t_s2[0];
			v_s3    <= v_s2;
			last_s3 <= last_s2;
			for (int i = 0; i < 3; i++) begin
				cam_s4[i] <= sum[i][CAM_W-1:0];
			end
			last_s4 <= last_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	assign out_valid = vld_s4;
	assign out_last  = last_s4;
	assign cam_x     = cam_s4[0];
	assign cam_y     = cam_s4[1];
	assign cam_z     = cam_s4[2];

endmodule

/* rtl/ppp_div.sv */
// ppp_div: radix-2 restoring divider pipeline, one quotient bit per stage, both axes.
// Computes (|cam| << FRAC) / |cam_z|. Depends on ppp_pkg.
module ppp_div import ppp_pkg::*; #(
	parameter int FRAC = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic                      in_last,
	input  logic signed [CAM_W-1:0]   cam_x,
	input  logic signed [CAM_W-1:0]   cam_y,
	input  logic signed [CAM_W-1:0]   cam_z,
	output logic                      out_valid,
	output div_tag_t                  out_tag,
	output logic [CAM_W+FRAC-1:0]     q_x,
	output logic [CAM_W+FRAC-1:0]     q_y
);

	localparam int NW = CAM_W + FRAC;

	logic [NW-1:0]    num_x_s [NW+1];
	logic [NW-1:0]    num_y_s [NW+1];
	logic [CAM_W-1:0] rem_x_s [NW+1];
	logic [CAM_W-1:0] rem_y_s [NW+1];
	logic [CAM_W-1:0] md_s    [NW+1];
	div_tag_t         tag_s   [NW+1];
	logic             vld_s   [NW+1];

	logic [CAM_W-1:0] ax, ay, az;
	div_tag_t         in_tag;

	assign ax = cam_x[CAM_W-1] ? CAM_W'(-cam_x) : cam_x;
	assign ay = cam_y[CAM_W-1] ? CAM_W'(-cam_y) : cam_y;
	assign az = cam_z[CAM_W-1] ? CAM_W'(-cam_z) : cam_z;

	always_comb begin
		in_tag.last  = in_last;
		in_tag.zero  = (cam_z == '0);
		in_tag.neg_x = cam_x[CAM_W-1] ^ cam_z[CAM_W-1];
		in_tag.neg_y = cam_y[CAM_W-1] ^ cam_z[CAM_W-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_x_s[0] <= {ax, FRAC'(0)};
			num_y_s[0] <= {ay, FRAC'(0)};
			rem_x_s[0] <= '0;
			rem_y_s[0] <= '0;
			md_s[0]    <= az;
			tag_s[0]   <= in_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	for (genvar i = 0; i < NW; i++) begin : g_stage
		logic [CAM_W:0] tx, ty;
		logic           gx, gy;

		assign tx = {rem_x_s[i], num_x_s[i][NW-1]};
		assign ty = {rem_y_s[i], num_y_s[i][NW-1]};
		assign gx = (tx >= {1'b0, md_s[i]});
		assign gy = (ty >= {1'b0, md_s[i]});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_x_s[i+1] <= gx ? CAM_W'(tx - {1'b0, md_s[i]}) : tx[CAM_W-1:0];
				rem_y_s[i+1] <= gy ? CAM_W'(ty - {1'b0, md_s[i]}) : ty[CAM_W-1:0];
				num_x_s[i+1] <= {num_x_s[i][NW-2:0], gx};
				num_y_s[i+1] <= {num_y_s[i][NW-2:0], gy};
				md_s[i+1]    <= md_s[i];
				tag_s[i+1]   <= tag_s[i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end
	end

	assign out_valid = vld_s[NW];
	assign out_tag   = tag_s[NW];
	assign q_x       = num_x_s[NW];
	assign q_y       = num_y_s[NW];

endmodule

/* rtl/ppp_axis.sv */
// ppp_axis: per-axis focal multiply, principal offset, image scale and clamp (4 stages).
// Depends on ppp_pkg.
module ppp_axis import ppp_pkg::*; #(
	parameter int FRAC = 16
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [CAM_W+FRAC-1:0] q,
	input  logic                  neg,
	input  logic [31:0]           f,
	input  logic [31:0]           c,
	input  logic [15:0]           scale,
	output logic [31:0]           pix,
	output logic                  sat
);

	localparam int NW   = CAM_W + FRAC;
	localparam int HW   = NW - 32;
	localparam int MAGW = HW + 64;

	logic [63:0]        lo_s1;
	logic [HW+31:0]     hi_s1;
	logic               neg_s1, neg_s2, neg_s3;
	logic [MAGW-1:0]    mag;
	logic               huge;
	logic signed [46:0] term;
	logic signed [47:0] sum_s2;
	logic               huge_s2, huge_s3;
	logic signed [64:0] prod_s3;
	logic signed [56:0] p;
	logic               fits;
	logic [31:0]        pix_s4;
	logic               sat_s4;

	assign mag  = (MAGW'(hi_s1) << (32 - FRAC)) + MAGW'(lo_s1 >> FRAC);
	assign huge = ((hi_s1 >> (FRAC + 13)) != '0) || ((mag >> 45) != '0);
	assign term = neg_s1 ? -$signed({1'b0, mag[45:0]}) : $signed({1'b0, mag[45:0]});
	assign p    = prod_s3[64:8];
	assign fits = (p[56:31] == '0) || (p[56:31] == '1);

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s1   <= q[31:0] * f;
			hi_s1   <= q[NW-1:32] * f;
			neg_s1  <= neg;
			sum_s2  <= 48'(term) + $signed({16'b0, c});
			huge_s2 <= huge;
			neg_s2  <= neg_s1;
			prod_s3 <= sum_s2 * $signed({1'b0, scale});
			huge_s3 <= huge_s2;
			neg_s3  <= neg_s2;
			if (huge_s3) begin
				if (scale == '0) begin
					pix_s4 <= '0;
					sat_s4 <= 1'b0;
				end else begin
					pix_s4 <= neg_s3 ? 32'h8000_0000 : 32'h7FFF_FFFF;
					sat_s4 <= 1'b1;
				end
			end else if (fits) begin
				pix_s4 <= p[31:0];
				sat_s4 <= 1'b0;
			end else begin
				pix_s4 <= p[56] ? 32'h8000_0000 : 32'h7FFF_FFFF;
				sat_s4 <= 1'b1;
			end
		end
	end

	assign pix = pix_s4;
	assign sat = sat_s4;

endmodule

/* rtl/pinhole_point_projection.sv */
// pinhole_point_projection: top level, register file, pipeline control and output skid.
// Depends on ppp_pkg, ppp_rot, ppp_div, ppp_axis.
//
// One world point (x, y, z, signed Q16.16) enters on the s_ beat channel, s_tlast marking
// the last point of a batch. Each point gives exactly one beat on the m_ channel: pixel
// x and y, zero-depth and saturation flags, and the batch mark on m_tlast.
// Pose, focal lengths, principal point and image scale are set over the APB port; the
// user must write them only while no point is in flight: the block does not enforce it.
// Registers sit at 8-byte strides from address 0. From input beat to output beat a point
// passes 4 rotation stages, one divider entry stage, 40 + COORD_FRAC_BITS divider stages
// (one quotient bit each), 4 per-axis scale stages and the output register.
// Throughput: one point per cycle while the receiver does not stall, set by the fully pipelined divider.
// If the receiver stalls, the pipeline keeps running until a result lands in the skid
// register; only then does the whole pipeline freeze and s_tready drop. Nothing is lost.
// Reset clears all valid bits and loads the default pose: identity rotation, zero
// translation, unit focal lengths, zero principal point, unit image scale.
module pinhole_point_projection import ppp_pkg::*; #(
	parameter int COORD_FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,  // world_x, world_y, world_z
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // pixel_x, pixel_y
	output logic [1:0]  m_tuser,  // zero_depth, saturated
	output logic        m_tlast
);

	localparam int NW = CAM_W + COORD_FRAC_BITS;
	localparam logic [63:0] FOCAL_RST =
		(64'd1 << (32 + COORD_FRAC_BITS)) | (64'd1 << COORD_FRAC_BITS);

	logic [63:0] rot_q, txy_q, focal_q, princ_q;
	logic [31:0] tz_q;
	logic [15:0] scale_q;

	logic en;
	logic rot_vld, rot_last;
	logic signed [CAM_W-1:0] cam_x, cam_y, cam_z;
	logic div_vld;
	div_tag_t div_tag;
	logic [NW-1:0] q_x, q_y;
	logic [31:0] pix_x, pix_y;
	logic sat_x, sat_y;

	post_tag_t post_tag_s [AXIS_LAT];
	logic      post_vld_s [AXIS_LAT];

	logic        fin_vld;
	logic [63:0] fin_data;
	logic [1:0]  fin_user;
	logic        fin_last;

	logic        out_vld_q, skid_vld_q;
	logic [63:0] out_data_q, skid_data_q;
	logic [1:0]  out_user_q, skid_user_q;
	logic        out_last_q, skid_last_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q   <= {QUAT_ONE, 48'd0};
			txy_q   <= '0;
			tz_q    <= '0;
			focal_q <= FOCAL_RST;
			princ_q <= '0;
			scale_q <= SCALE_ONE;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx_t'(paddr[5:3]))
				REG_ROT:   rot_q   <= pwdata;
				REG_TXY:   txy_q   <= pwdata;
				REG_TZ:    tz_q    <= pwdata[31:0];
				REG_FOCAL: focal_q <= pwdata;
				REG_PRINC: princ_q <= pwdata;
				REG_SCALE: scale_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[5:3]))
			REG_ROT:   prdata = rot_q;
			REG_TXY:   prdata = txy_q;
			REG_TZ:    prdata = {32'd0, tz_q};
			REG_FOCAL: prdata = focal_q;
			REG_PRINC: prdata = princ_q;
			REG_SCALE: prdata = {48'd0, scale_q};
			default:   prdata = '0;
		endcase
	end

	// whole pipeline freezes only while the skid holds a beat
	assign en       = !skid_vld_q;
	assign s_tready = en;

	ppp_rot u_rot (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.wx        ($signed(s_tdata[31:0])),
		.wy        ($signed(s_tdata[63:32])),
		.wz        ($signed(s_tdata[95:64])),
		.in_last   (s_tlast),
		.quat      (rot_q),
		.txy       (txy_q),
		.tz        (tz_q),
		.out_valid (rot_vld),
		.out_last  (rot_last),
		.cam_x     (cam_x),
		.cam_y     (cam_y),
		.cam_z     (cam_z)
	);

	ppp_div #(.FRAC(COORD_FRAC_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (rot_vld),
		.in_last   (rot_last),
		.cam_x     (cam_x),
		.cam_y     (cam_y),
		.cam_z     (cam_z),
		.out_valid (div_vld),
		.out_tag   (div_tag),
		.q_x       (q_x),
		.q_y       (q_y)
	);

	ppp_axis #(.FRAC(COORD_FRAC_BITS)) u_axis_x (
		.clk   (clk),
		.en    (en),
		.q     (q_x),
		.neg   (div_tag.neg_x),
		.f     (focal_q[63:32]),
		.c     (princ_q[63:32]),
		.scale (scale_q),
		.pix   (pix_x),
		.sat   (sat_x)
	);

	ppp_axis #(.FRAC(COORD_FRAC_BITS)) u_axis_y (
		.clk   (clk),
		.en    (en),
		.q     (q_y),
		.neg   (div_tag.neg_y),
		.f     (focal_q[31:0]),
		.c     (princ_q[31:0]),
		.scale (scale_q),
		.pix   (pix_y),
		.sat   (sat_y)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			post_tag_s[0].last <= div_tag.last;
			post_tag_s[0].zero <= div_tag.zero;
			for (int i = 1; i < AXIS_LAT; i++) begin
				post_tag_s[i] <= post_tag_s[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXIS_LAT; i++) begin
				post_vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			post_vld_s[0] <= div_vld;
			for (int i = 1; i < AXIS_LAT; i++) begin
				post_vld_s[i] <= post_vld_s[i-1];
			end
		end
	end

	assign fin_vld  = post_vld_s[AXIS_LAT-1] && en;
	assign fin_last = post_tag_s[AXIS_LAT-1].last;
	assign fin_data = post_tag_s[AXIS_LAT-1].zero ? 64'd0 : {pix_y, pix_x};
	assign fin_user = post_tag_s[AXIS_LAT-1].zero ? 2'b01 : {sat_x | sat_y, 1'b0};

	always_ff @(posedge clk) begin
		if (m_tready || !out_vld_q) begin
			if (skid_vld_q) begin
				out_data_q <= skid_data_q;
				out_user_q <= skid_user_q;
				out_last_q <= skid_last_q;
			end else begin
				out_data_q <= fin_data;
				out_user_q <= fin_user;
				out_last_q <= fin_last;
			end
		end else if (fin_vld) begin
			skid_data_q <= fin_data;
			skid_user_q <= fin_user;
			skid_last_q <= fin_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (m_tready || !out_vld_q) begin
			out_vld_q  <= skid_vld_q || fin_vld;
			skid_vld_q <= 1'b0;
		end else if (fin_vld) begin
			skid_vld_q <= 1'b1;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

`ifndef NO_ASSERTIONS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid holds a beat while output register is empty");

	a_zero_depth_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata == 64'd0 && !m_tuser[1]))
		else $error("zero depth beat carries nonzero pixels or saturation");

	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> (m_tdata[31:0] == 32'h7FFF_FFFF
			|| m_tdata[31:0] == 32'h8000_0000 || m_tdata[63:32] == 32'h7FFF_FFFF
			|| m_tdata[63:32] == 32'h8000_0000))
		else $error("saturated beat without a clipped coordinate");

	a_stall_freezes_in: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready && skid_vld_q) |=> !s_tready)
		else $error("input accepted while output and skid are both full");
`endif

endmodule

/* bench/tb_pinhole_point_projection.sv */
// Testbench for pinhole_point_projection: streams world points through the block and checks
// each pixel beat against a built-in fixed-point projection predictor.
// Depends on rtl/ppp_pkg.sv and rtl/pinhole_point_projection.sv.
module tb_pinhole_point_projection;
	timeunit 1ns;
	timeprecision 1ps;
	import ppp_pkg::*;

	localparam int FRAC = 16;
	localparam int WATCHDOG = 20000;

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic               zero;
		logic               sat;
		logic               last;
	} pixel_t;

	typedef struct {
		logic [31:0] wx;
		logic [31:0] wy;
		logic [31:0] wz;
		logic        last;
		logic        has_exp;
		pixel_t      exp_pix;
	} point_row_t;

	logic clk, arst_n;
	logic psel, penable, pwrite, pready;
	logic [5:0] paddr;
	logic [63:0] pwdata, prdata;
	logic s_tvalid, s_tready, s_tlast;
	logic [95:0] s_tdata;
	logic m_tvalid, m_tready, m_tlast;
	logic [63:0] m_tdata;
	logic [1:0] m_tuser;

	pinhole_point_projection #(.COORD_FRAC_BITS(FRAC)) i_dut (.*);

	logic [63:0] cur_quat, cur_txy, cur_fxy, cur_cxy;
	logic [31:0] cur_tz;
	logic [15:0] cur_scale;

	pixel_t pixel_q[$];
	int errors = 0;
	int idle_cycles = 0;
	int send_gap = 0, recv_gap = 0;
	bit hold_off = 0;
	bit done = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint fl_shift(longint x, int s);
		return x >>> s;
	endfunction

	function automatic logic [31:0] axis_pixel(longint num, longint den, logic [31:0] f,
			logic [31:0] c, logic [15:0] scale, ref logic sat);
		logic [63:0] mn, md, r, lo, hi, mag;
		bit neg, huge;
		longint term, acc, p;
		mn = num < 0 ? -num : num;
		md = den < 0 ? -den : den;
		neg = (num < 0) != (den < 0);
		r = (mn << FRAC) / md;
		lo = r[31:0] * {32'd0, f};
		hi = (r >> 32) * {32'd0, f};
		mag = 0;
		huge = 0;
		if (hi >= (64'd1 << (FRAC + 13)))
			huge = 1;
		else begin
			mag = (hi << (32 - FRAC)) + (lo >> FRAC);
			if (mag >= (64'd1 << 45)) huge = 1;
		end
		if (huge) begin
			if (scale == 0) return 0;
			sat = 1;
			return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
		term = neg ? -longint'(mag) : longint'(mag);
		acc = term + longint'({32'd0, c});
		p = fl_shift(acc * longint'({48'd0, scale}), 8);
		if (p > 64'sd2147483647) begin p = 64'sd2147483647; sat = 1; end
		if (p < -64'sd2147483648) begin p = -64'sd2147483648; sat = 1; end
		return p[31:0];
	endfunction

	function automatic pixel_t project_point(logic [31:0] wx, logic [31:0] wy,
			logic [31:0] wz, logic last);
		longint v[3], q[3], cr[3], t[3], u[3], cam[3], w;
		logic sat;
		pixel_t res;
		sat = 0;
		v[0] = longint'($signed(wx));
		v[1] = longint'($signed(wy));
		v[2] = longint'($signed(wz));
		w = longint'($signed(cur_quat[63:48]));
		q[0] = longint'($signed(cur_quat[47:32]));
		q[1] = longint'($signed(cur_quat[31:16]));
		q[2] = longint'($signed(cur_quat[15:0]));
		cr[0] = q[1] * v[2] - q[2] * v[1];
		cr[1] = q[2] * v[0] - q[0] * v[2];
		cr[2] = q[0] * v[1] - q[1] * v[0];
		for (int i = 0; i < 3; i++) t[i] = fl_shift(cr[i], 13);
		u[0] = w * t[0] + q[1] * t[2] - q[2] * t[1];
		u[1] = w * t[1] + q[2] * t[0] - q[0] * t[2];
		u[2] = w * t[2] + q[0] * t[1] - q[1] * t[0];
		for (int i = 0; i < 3; i++) cam[i] = v[i] + fl_shift(u[i], 14);
		cam[0] += longint'($signed(cur_txy[63:32]));
		cam[1] += longint'($signed(cur_txy[31:0]));
		cam[2] += longint'($signed(cur_tz));
		res.last = last;
		if (cam[2] == 0) begin
			res.px = 0;
			res.py = 0;
			res.zero = 1;
			res.sat = 0;
		end else begin
			res.px = axis_pixel(cam[0], cam[2], cur_fxy[63:32], cur_cxy[63:32], cur_scale, sat);
			res.py = axis_pixel(cam[1], cam[2], cur_fxy[31:0], cur_cxy[31:0], cur_scale, sat);
			res.zero = 0;
			res.sat = sat;
		end
		return res;
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [63:0] value);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= 6'(idx) << 3;
		pwdata <= value;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (idx)
			REG_ROT:   cur_quat = value;
			REG_TXY:   cur_txy = value;
			REG_TZ:    cur_tz = value[31:0];
			REG_FOCAL: cur_fxy = value;
			REG_PRINC: cur_cxy = value;
			REG_SCALE: cur_scale = value[15:0];
			default: ;
		endcase
	endtask

	task automatic send_point(logic [31:0] wx, logic [31:0] wy, logic [31:0] wz, logic last,
			bit has_exp, pixel_t exp_pix);
		pixel_t pred;
		int idle;
		idle = 0;
		while (send_gap > 0 && $urandom_range(99) < send_gap) idle++;
		if (idle > 0) begin
			s_tvalid <= 0;
			repeat (idle) @(posedge clk);
		end
		pred = project_point(wx, wy, wz, last);
		if (has_exp && pred !== exp_pix) begin
			$display("%0t predictor disagrees with table: exp %h got %h", $realtime, exp_pix, pred);
			errors++;
		end
		s_tvalid <= 1;
		s_tdata <= {wz, wy, wx};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		pixel_q.insert(pixel_q.size(), has_exp ? exp_pix : pred);
	endtask

	task automatic drain;
		s_tvalid <= 0;
		while (pixel_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(4))
			0: return $urandom;
			1: return 32'($signed($urandom_range(2000)) - 1000) << FRAC;
			2: return $urandom_range(32'hFFFF);
			default: return 32'($signed($urandom_range(200000)) - 100000) << 8;
		endcase
	endfunction

	task automatic random_points(int n);
		logic [31:0] z;
		for (int i = 0; i < n; i++) begin
			z = $urandom_range(9) == 0 ? 32'(-$signed(cur_tz)) : rand_coord();
			send_point(rand_coord(), rand_coord(), z, $urandom_range(7) == 0, 0, '0);
		end
	endtask

	always @(posedge clk) begin
		if (hold_off)
			m_tready <= 0;
		else
			m_tready <= !(recv_gap > 0 && $urandom_range(99) < recv_gap);
	end

	always @(posedge clk) begin
		pixel_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[31:0], m_tdata[63:32], m_tuser[0], m_tuser[1], m_tlast};
			if (pixel_q.size() == 0) begin
				$display("%0t unexpected beat: got %h", $realtime, got);
				errors++;
			end else begin
				want = pixel_q.pop_front();
				if (got !== want) begin
					$display("%0t mismatch: exp x=%h y=%h z=%b s=%b l=%b got x=%h y=%h z=%b s=%b l=%b",
						$realtime, want.px, want.py, want.zero, want.sat, want.last,
						got.px, got.py, got.zero, got.sat, got.last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_off || done || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("tb_pinhole_point_projection NOT OK");
			$finish;
		end
	end

	point_row_t dir_rows[$];

	initial begin
		point_row_t r;
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		s_tvalid = 0;
		s_tdata = 0;
		s_tlast = 0;
		m_tready = 0;
		cur_quat = {QUAT_ONE, 48'd0};
		cur_txy = 0;
		cur_tz = 0;
		cur_fxy = {32'h0001_0000, 32'h0001_0000};
		cur_cxy = 0;
		cur_scale = SCALE_ONE;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// identity pose after reset: pixel = x/z, y/z
		dir_rows = '{
			'{32'h0002_0000, 32'h0003_0000, 32'h0001_0000, 1, 1, '{32'h0002_0000, 32'h0003_0000, 0, 0, 1}},
			'{32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 0, 1, '{0, 0, 1, 0, 0}},
			'{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 0, 1,
				'{32'h8000_0000, 32'h7FFF_FFFF, 0, 1, 0}},
			'{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1, 0, '0},
			'{32'h0004_0000, 32'hFFFC_0000, 32'hFFFE_0000, 0, 0, '0},
			'{32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 0, 0, '0},
			'{32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 1, 0, '0}
		};
		foreach (dir_rows[i]) begin
			r = dir_rows[i];
			send_point(r.wx, r.wy, r.wz, r.last, r.has_exp, r.exp_pix);
		end
		drain();

		// non-unit rotation, offsets, extreme scale settings
		write_reg(REG_ROT, {16'h2D41, 16'h2D41, 16'h0000, 16'h0000});
		write_reg(REG_TXY, {32'h0010_0000, 32'hFFF0_0000});
		write_reg(REG_TZ, 32'h0020_0000);
		write_reg(REG_FOCAL, {32'h0200_0000, 32'h01F0_0000});
		write_reg(REG_PRINC, {32'h0140_0000, 32'h00F0_0000});
		write_reg(REG_SCALE, 16'd0);
		send_point(32'h0001_0000, 32'h0001_0000, 32'h8000_0000, 0, 0, '0);
		send_point(32'h0001_0000, 32'h0002_0000, 32'hFFE0_0000, 1, 0, '0);
		drain();
		write_reg(REG_SCALE, 16'hFFFF);
		write_reg(REG_ROT, 64'hFFFF_FFFF_FFFF_FFFF);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, '0);
		send_point(32'h0001_0000, 32'h8000_0000, 32'h0005_0000, 1, 0, '0);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			send_gap = ph == 0 ? 10 : (ph == 1 ? 69 : 0);
			recv_gap = ph == 0 ? 69 : (ph == 1 ? 10 : 0);
			write_reg(REG_ROT, ph == 2 ? {QUAT_ONE, 48'd0} : {$urandom, $urandom});
			write_reg(REG_TXY, {$urandom, $urandom});
			write_reg(REG_TZ, ph == 1 ? 32'h8000_0000 : 32'($urandom_range(20000)) << 8);
			write_reg(REG_FOCAL, ph == 0 ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom, $urandom} >> 8);
			write_reg(REG_PRINC, ph == 1 ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom, $urandom});
			write_reg(REG_SCALE, ph == 2 ? SCALE_ONE : 16'($urandom));
			if (ph == 2) begin
				fork
					begin
						hold_off = 1;
						repeat (300) @(posedge clk);
						hold_off = 0;
					end
					random_points(250);
				join
			end else
				random_points(250);
			drain();
		end
		done = 1;

		if (errors == 0)
			$display("tb_pinhole_point_projection OK");
		else
			$display("tb_pinhole_point_projection NOT OK");
		$finish;
	end
endmodule
